[rtl/core/bisu_pkg.sv]
// Package for the bounded integer set operations unit.
// Holds function codes, controller states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
package bisu_pkg;

  localparam int CAP_DEFAULT = 32;
  localparam int SIZE_W      = 6;
  localparam int DATA_W      = 32;
  localparam int FUNC_W      = 3;

  localparam logic [FUNC_W-1:0] FN_INS_A = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INS_B = 3'd1;
  localparam logic [FUNC_W-1:0] FN_CLEAR = 3'd2;
  localparam logic [FUNC_W-1:0] FN_UNION = 3'd3;
  localparam logic [FUNC_W-1:0] FN_INTER = 3'd4;
  localparam logic [FUNC_W-1:0] FN_AMB   = 3'd5;
  localparam logic [FUNC_W-1:0] FN_BMA   = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_CHK,
    ST_FETCH,
    ST_LATCH,
    ST_SCAN,
    ST_DECIDE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic              wr_a;
    logic              wr_b;
    logic              clr;
    logic              l_is_b;
    logic [SIZE_W-1:0] addr_a;
    logic [SIZE_W-1:0] addr_b;
    logic              cand_load;
    logic              scan_clr;
    logic              pv1;
    logic              pv2;
    logic              pend_load;
    logic              out_load;
    logic              out_has;
    logic              out_last;
    logic              out_status;
  } cmd_t;

  typedef struct packed {
    logic [SIZE_W-1:0] a_size;
    logic [SIZE_W-1:0] b_size;
    logic              hit1;
    logic              hit2;
    logic              out_free;
  } stat_t;

endpackage

[rtl/core/bisu_dp.sv]
// Datapath: the two set memories, sizes, candidate and compare flags,
// pending word and output register. Depends on bisu_pkg.
`timescale 1ns / 1ps
module bisu_dp #(
  parameter int CAPACITY = bisu_pkg::CAP_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bisu_pkg::cmd_t              cmd,
  input  logic [bisu_pkg::DATA_W-1:0] wr_value,
  input  logic                        out_ready,
  output bisu_pkg::stat_t             stat,
  output logic                        out_valid,
  output logic [bisu_pkg::DATA_W-1:0] out_element,
  output logic                        out_has_element,
  output logic                        out_last,
  output logic                        out_status
);
  import bisu_pkg::*;

  localparam int ADR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [DATA_W-1:0] mem_a [CAPACITY];
  logic [DATA_W-1:0] mem_b [CAPACITY];
  logic [DATA_W-1:0] rd_a_r, rd_b_r;
  logic [SIZE_W-1:0] a_size_r, b_size_r;
  logic [DATA_W-1:0] cand_r, pend_r;
  logic              pv1_r, pv2_r, hit1_r, hit2_r;
  logic              ov_r, has_r, last_r, st_r;
  logic [DATA_W-1:0] oel_r;
  logic [DATA_W-1:0] r_data, l_data;

  always_ff @(posedge clk) begin
    if (cmd.wr_a) begin
      mem_a[a_size_r[ADR_W-1:0]] <= wr_value;
    end
    if (cmd.wr_b) begin
      mem_b[b_size_r[ADR_W-1:0]] <= wr_value;
    end
    rd_a_r <= mem_a[cmd.addr_a[ADR_W-1:0]];
    rd_b_r <= mem_b[cmd.addr_b[ADR_W-1:0]];
  end

  assign r_data = cmd.l_is_b ? rd_a_r : rd_b_r;
  assign l_data = cmd.l_is_b ? rd_b_r : rd_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_size_r <= '0;
      b_size_r <= '0;
      ov_r     <= 1'b0;
      pv1_r    <= 1'b0;
      pv2_r    <= 1'b0;
      hit1_r   <= 1'b0;
      hit2_r   <= 1'b0;
    end else begin
      if (cmd.clr) begin
        a_size_r <= '0;
        b_size_r <= '0;
      end else begin
        if (cmd.wr_a) a_size_r <= a_size_r + SIZE_W'(1);
        if (cmd.wr_b) b_size_r <= b_size_r + SIZE_W'(1);
      end
      pv1_r <= cmd.pv1;
      pv2_r <= cmd.pv2;
      if (cmd.scan_clr) begin
        hit1_r <= 1'b0;
        hit2_r <= 1'b0;
      end else begin
        if (pv1_r && (r_data == cand_r)) hit1_r <= 1'b1;
        if (pv2_r && (l_data == cand_r)) hit2_r <= 1'b1;
      end
      if (cmd.out_load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cand_load) cand_r <= l_data;
    if (cmd.pend_load) pend_r <= cand_r;
    if (cmd.out_load) begin
      oel_r  <= cmd.out_has ? pend_r : '0;
      has_r  <= cmd.out_has;
      last_r <= cmd.out_last;
      st_r   <= cmd.out_status;
    end
  end

  assign stat.a_size   = a_size_r;
  assign stat.b_size   = b_size_r;
  assign stat.hit1     = hit1_r;
  assign stat.hit2     = hit2_r;
  assign stat.out_free = !ov_r || out_ready;

  assign out_valid       = ov_r;
  assign out_element     = oel_r;
  assign out_has_element = has_r;
  assign out_last        = last_r;
  assign out_status      = st_r;

endmodule

[rtl/core/bisu_ctrl.sv]
// Controller: sequences inserts, clears and the candidate-by-candidate scans.
// Depends on bisu_pkg; drives bisu_dp through cmd_t.
`timescale 1ns / 1ps
module bisu_ctrl #(
  parameter int CAPACITY = bisu_pkg::CAP_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [bisu_pkg::FUNC_W-1:0] in_func,
  output logic                        in_ready,
  input  bisu_pkg::stat_t             stat,
  output bisu_pkg::cmd_t              cmd
);
  import bisu_pkg::*;

  localparam logic [SIZE_W-1:0] CAP_S = SIZE_W'(CAPACITY);

  state_t            state_r, state_nxt;
  logic [FUNC_W-1:0] op_r, op_nxt;
  logic              phase_r, phase_nxt;
  logic [SIZE_W-1:0] i_r, i_nxt, j_r, j_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic              ack_st_r, ack_st_nxt;

  logic              l_is_b, chk1, chk2, want_found, emit;
  logic [SIZE_W-1:0] ln, rn, lim1, lim2, lim;

  always_comb begin
    l_is_b     = (op_r == FN_BMA) || ((op_r == FN_UNION) && phase_r);
    chk1       = !((op_r == FN_UNION) && !phase_r);
    chk2       = ((op_r == FN_UNION) && phase_r) || (op_r == FN_INTER);
    want_found = (op_r == FN_INTER);
    ln         = l_is_b ? stat.b_size : stat.a_size;
    rn         = l_is_b ? stat.a_size : stat.b_size;
    lim1       = chk1 ? rn : '0;
    lim2       = chk2 ? i_r : '0;
    lim        = (lim1 > lim2) ? lim1 : lim2;
    emit       = (!chk1 || (want_found ? stat.hit1 : !stat.hit1)) && !(chk2 && stat.hit2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      op_r     <= FN_CLEAR;
      phase_r  <= 1'b0;
      i_r      <= '0;
      j_r      <= '0;
      pend_v_r <= 1'b0;
      ack_st_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      op_r     <= op_nxt;
      phase_r  <= phase_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      pend_v_r <= pend_v_nxt;
      ack_st_r <= ack_st_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    phase_nxt  = phase_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    pend_v_nxt = pend_v_r;
    ack_st_nxt = ack_st_r;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.l_is_b = l_is_b;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op_nxt     = in_func;
          ack_st_nxt = 1'b0;
          state_nxt  = ST_ACK;
          unique case (in_func) inside
            FN_INS_A: begin
              if (stat.a_size < CAP_S) cmd.wr_a = 1'b1;
              else ack_st_nxt = 1'b1;
            end
            FN_INS_B: begin
              if (stat.b_size < CAP_S) cmd.wr_b = 1'b1;
              else ack_st_nxt = 1'b1;
            end
            FN_CLEAR: cmd.clr = 1'b1;
            FN_UNION, FN_INTER, FN_AMB, FN_BMA: begin
              i_nxt      = '0;
              phase_nxt  = 1'b0;
              pend_v_nxt = 1'b0;
              state_nxt  = ST_CHK;
            end
            default: ;
          endcase
        end
      end
      ST_ACK: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_last   = 1'b1;
          cmd.out_status = ack_st_r;
          state_nxt      = ST_IDLE;
        end
      end
      ST_CHK: begin
        if (i_r < ln) begin
          state_nxt = ST_FETCH;
        end else if ((op_r == FN_UNION) && !phase_r) begin
          phase_nxt = 1'b1;
          i_nxt     = '0;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_has  = pend_v_r;
          cmd.out_last = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FETCH: begin
        if (l_is_b) cmd.addr_b = i_r;
        else cmd.addr_a = i_r;
        state_nxt = ST_LATCH;
      end
      ST_LATCH: begin
        cmd.cand_load = 1'b1;
        cmd.scan_clr  = 1'b1;
        j_nxt         = '0;
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.addr_a = j_r;
        cmd.addr_b = j_r;
        cmd.pv1    = chk1 && (j_r < rn);
        cmd.pv2    = chk2 && (j_r < i_r);
        if (j_r < lim) j_nxt = j_r + SIZE_W'(1);
        else state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (emit && pend_v_r) begin
          state_nxt = ST_FLUSH;
        end else begin
          if (emit) begin
            cmd.pend_load = 1'b1;
            pend_v_nxt    = 1'b1;
          end
          i_nxt     = i_r + SIZE_W'(1);
          state_nxt = ST_CHK;
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_has   = 1'b1;
          cmd.pend_load = 1'b1;
          i_nxt         = i_r + SIZE_W'(1);
          state_nxt     = ST_CHK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

[rtl/core/bounded_int_set_ops_unit.sv]
// Top level of the bounded integer set operations unit.
// Instantiates bisu_ctrl and bisu_dp; depends on bisu_pkg.
//
//   channel  dir  handshake            word
//   in       in   in_valid/in_ready    in_func, in_value
//   out      out  out_valid/out_ready  out_element, out_has_element, out_last, out_status
//
// Insert, clear and unused codes go through ST_ACK and then wait for a free output register.
// A set operation takes each left element through ST_CHK, ST_FETCH, ST_LATCH,
// ST_SCAN up to max(right size, index) and ST_DECIDE, plus ST_FLUSH when a word
// is flushed; the scan is set by the single read port of each set memory.
// Reset clears the sizes and control; the memories hold until written.
// A stalled output holds the controller; one word may wait in the output register.
`timescale 1ns / 1ps
module bounded_int_set_ops_unit #(
  parameter int CAPACITY = bisu_pkg::CAP_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic        [bisu_pkg::FUNC_W-1:0] in_func,
  input  logic signed [bisu_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [bisu_pkg::DATA_W-1:0] out_element,
  output logic                               out_has_element,
  output logic                               out_last,
  output logic                               out_status
);
  import bisu_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [DATA_W-1:0] el;

  bisu_ctrl #(.CAPACITY(CAPACITY)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bisu_dp #(.CAPACITY(CAPACITY)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .wr_value        (in_value),
    .out_ready       (out_ready),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_element     (el),
    .out_has_element (out_has_element),
    .out_last        (out_last),
    .out_status      (out_status)
  );

  assign out_element = el;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_element |-> out_last)
    else $error("empty word not last");

  a_status_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> !out_has_element && out_element == '0)
    else $error("drop flag on element word");

endmodule

[tb/bounded_int_set_ops_unit_tb.sv]
// Testbench for the bounded integer set operations unit: drives insert, clear and
// set-operation words, predicts every result word and checks them in a scoreboard class.
// Depends on bisu_pkg and bounded_int_set_ops_unit.
`timescale 1ns / 1ps
module bounded_int_set_ops_unit_tb;
  import bisu_pkg::*;

  localparam int CAP = CAP_DEFAULT;
  localparam int LIMIT = 3000000;
  localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [31:0] element;
    logic has;
    logic last;
    logic status;
  } set_word_t;

  class set_scoreboard;
    logic [31:0] list_a[$];
    logic [31:0] list_b[$];
    set_word_t pending[$];
    int mismatches;

    function void push(logic [31:0] e, logic h, logic l, logic s);
      set_word_t w;
      w.element = e;
      w.has = h;
      w.last = l;
      w.status = s;
      pending.push_back(w);
    endfunction

    function bit holds(logic [31:0] q[$], logic [31:0] v);
      foreach (q[i]) if (q[i] == v) return 1;
      return 0;
    endfunction

    function void finish_op(int start);
      if (pending.size() == start) push(0, 0, 1, 0);
      else pending[pending.size()-1].last = 1;
    endfunction

    function void diff(logic [31:0] l[$], logic [31:0] r[$]);
      int start;
      start = pending.size();
      foreach (l[i]) if (!holds(r, l[i])) push(l[i], 1, 0, 0);
      finish_op(start);
    endfunction

    function void note_input(logic [2:0] fn, logic [31:0] v);
      logic [31:0] given[$];
      int start;
      start = pending.size();
      case (fn)
        FN_INS_A: begin
          if (list_a.size() < CAP) begin
            list_a.push_back(v);
            push(0, 0, 1, 0);
          end else begin
            push(0, 0, 1, 1);
          end
        end
        FN_INS_B: begin
          if (list_b.size() < CAP) begin
            list_b.push_back(v);
            push(0, 0, 1, 0);
          end else begin
            push(0, 0, 1, 1);
          end
        end
        FN_CLEAR: begin
          list_a.delete();
          list_b.delete();
          push(0, 0, 1, 0);
        end
        FN_UNION: begin
          foreach (list_a[i]) begin
            given.push_back(list_a[i]);
            push(list_a[i], 1, 0, 0);
          end
          foreach (list_b[i]) if (!holds(given, list_b[i])) begin
            given.push_back(list_b[i]);
            push(list_b[i], 1, 0, 0);
          end
          finish_op(start);
        end
        FN_INTER: begin
          foreach (list_a[i])
            if (holds(list_b, list_a[i]) && !holds(given, list_a[i])) begin
              given.push_back(list_a[i]);
              push(list_a[i], 1, 0, 0);
            end
          finish_op(start);
        end
        FN_AMB: diff(list_a, list_b);
        FN_BMA: diff(list_b, list_a);
        default: push(0, 0, 1, 0);
      endcase
    endfunction

    function void check_word(set_word_t got);
      set_word_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp el=%0d has=%b last=%b st=%b, got el=%0d has=%b last=%b st=%b",
                   exp.element, exp.has, exp.last, exp.status,
                   got.element, got.has, got.last, got.status);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  logic [FUNC_W-1:0] in_func = '0;
  logic signed [DATA_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [DATA_W-1:0] out_element;
  logic out_has_element, out_last, out_status;

  set_scoreboard sb;
  int cycles = 0;
  int burst_left = 0;
  bit stall_on = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  bounded_int_set_ops_unit dut (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
    if (rst_n && out_valid && out_ready)
      sb.check_word({out_element, out_has_element, out_last, out_status});
  end

  always @(negedge clk) begin
    if (stall_on) out_ready <= ($urandom_range(0, 3) == 0);
    else out_ready <= ($urandom_range(0, 9) != 0);
    if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
  end

  task automatic send_word(logic [2:0] fn, logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap > 0) begin
        in_valid <= 0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_func <= fn;
    in_value <= v;
    in_valid <= 1;
    do @(posedge clk); while (!in_ready);
    sb.note_input(fn, v);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value(int pool);
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom;
      default: return $urandom_range(0, pool);
    endcase
  endfunction

  initial begin
    logic [2:0] fn;
    int pool;
    sb = new();
    repeat (2) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    send_word(FN_UNION, 0);
    send_word(FN_INTER, 0);
    send_word(FN_AMB, 0);
    send_word(FN_BMA, 0);
    send_word(FN_INS_A, 32'h8000_0000);
    send_word(FN_INS_A, 32'h7fff_ffff);
    send_word(FN_INS_A, 32'h7fff_ffff);
    send_word(FN_INS_A, 0);
    send_word(FN_UNION, 0);
    send_word(FN_INS_B, 32'hffff_ffff);
    send_word(FN_INS_B, 32'h7fff_ffff);
    send_word(FN_INS_B, 32'hffff_ffff);
    send_word(FN_UNION, 0);
    send_word(FN_INTER, 0);
    send_word(FN_AMB, 0);
    send_word(FN_BMA, 0);
    send_word(FN_UNUSED, 32'h5555_aaaa);
    send_word(FN_CLEAR, 0);
    send_word(FN_INS_B, 5);
    send_word(FN_INS_B, 5);
    send_word(FN_UNION, 0);
    send_word(FN_CLEAR, 32'hffff_ffff);
    for (int i = 0; i < 33; i++) send_word(FN_INS_A, i);
    for (int i = 0; i < 33; i++) send_word(FN_INS_B, i + 16);
    send_word(FN_UNION, 0);
    send_word(FN_INTER, 0);
    send_word(FN_AMB, 0);
    send_word(FN_BMA, 0);
    for (int r = 0; r < 3; r++) begin
      pool = $urandom_range(0, 1) ? 7 : 40;
      send_word(FN_CLEAR, $urandom);
      repeat ($urandom_range(0, 9)) begin
        fn = $urandom_range(0, 1) ? FN_INS_A : FN_INS_B;
        send_word(fn, pick_value(pool));
      end
      repeat ($urandom_range(1, 3)) begin
        fn = 3'($urandom_range(FN_UNION, FN_UNUSED));
        send_word(fn, $urandom);
      end
    end
    in_valid <= 0;
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

[bounded_int_set_ops_unit.f]
rtl/core/bisu_pkg.sv
rtl/core/bisu_dp.sv
rtl/core/bisu_ctrl.sv
rtl/core/bounded_int_set_ops_unit.sv
tb/bounded_int_set_ops_unit_tb.sv
